// ----- rtl/core/ipdfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdfs_pkg: shared types and constants of the IR pulse-distance frame sender
// Request codes, sequencer phases, register indexes, reset values and the
// structs that travel between the configuration, sequencer and output stages.
// ----------------------------------------------------------------------------
package ipdfs_pkg;

    // Width of the segment index inside one frame.
    localparam int SEG_W = 7;

    // Width of the configuration write port and its register index.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    // Data bits: address, address again, command, inverted command.
    localparam logic [SEG_W-1:0] ADDR_END_IDX = SEG_W'(32);
    localparam logic [SEG_W-1:0] CMD_END_IDX  = SEG_W'(48);

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_START_MARK  = 3'd1,
        PH_START_SPACE = 3'd2,
        PH_BITS        = 3'd3,
        PH_GAP         = 3'd4
    } t_phase;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_MARK  = 3'd0,
        CFG_START_SPACE = 3'd1,
        CFG_BIT_MARK    = 3'd2,
        CFG_ONE_SPACE   = 3'd3,
        CFG_ZERO_SPACE  = 3'd4,
        CFG_REPEAT_GAP  = 3'd5,
        CFG_REPEAT_CNT  = 3'd6,
        CFG_TICKS_MS    = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_START_MARK  = 16'd4500;
    localparam logic [15:0] RST_START_SPACE = 16'd4500;
    localparam logic [15:0] RST_BIT_MARK    = 16'd560;
    localparam logic [15:0] RST_ONE_SPACE   = 16'd1690;
    localparam logic [15:0] RST_ZERO_SPACE  = 16'd560;
    localparam logic [7:0]  RST_REPEAT_GAP  = 8'd100;
    localparam logic [7:0]  RST_REPEAT_CNT  = 8'd1;
    localparam logic [15:0] RST_TICKS_MS    = 16'd1000;

    typedef struct packed {
        logic [15:0] start_mark_ticks;
        logic [15:0] start_space_ticks;
        logic [15:0] bit_mark_ticks;
        logic [15:0] one_space_ticks;
        logic [15:0] zero_space_ticks;
        logic [7:0]  repeat_gap_ms;
        logic [7:0]  repeat_count;
        logic [15:0] ticks_per_ms;
    } t_cfg;

    typedef struct packed {
        logic ir_on;
        logic active;
        logic frame_end;
        logic status;
    } t_result;

endpackage

// ----- rtl/core/ipdfs_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdfs_cfg: configuration register file
// Eight write-only timing registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module ipdfs_cfg
    import ipdfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_START_MARK:  n_cfg.start_mark_ticks  = i_cfg_wdata;
                CFG_START_SPACE: n_cfg.start_space_ticks = i_cfg_wdata;
                CFG_BIT_MARK:    n_cfg.bit_mark_ticks    = i_cfg_wdata;
                CFG_ONE_SPACE:   n_cfg.one_space_ticks   = i_cfg_wdata;
                CFG_ZERO_SPACE:  n_cfg.zero_space_ticks  = i_cfg_wdata;
                CFG_REPEAT_GAP:  n_cfg.repeat_gap_ms     = i_cfg_wdata[7:0];
                CFG_REPEAT_CNT:  n_cfg.repeat_count      = i_cfg_wdata[7:0];
                CFG_TICKS_MS:    n_cfg.ticks_per_ms      = i_cfg_wdata;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_mark_ticks  <= RST_START_MARK;
            r_cfg.start_space_ticks <= RST_START_SPACE;
            r_cfg.bit_mark_ticks    <= RST_BIT_MARK;
            r_cfg.one_space_ticks   <= RST_ONE_SPACE;
            r_cfg.zero_space_ticks  <= RST_ZERO_SPACE;
            r_cfg.repeat_gap_ms     <= RST_REPEAT_GAP;
            r_cfg.repeat_count      <= RST_REPEAT_CNT;
            r_cfg.ticks_per_ms      <= RST_TICKS_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/ipdfs_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdfs_seq: frame sequencer
// Holds the frame state and advances it by one request per accepted beat,
// producing the result that shows the state after that beat.
// ----------------------------------------------------------------------------
module ipdfs_seq
    import ipdfs_pkg::*;
#(
    parameter int FRAME_SEGMENTS = 65,
    parameter int DURATION_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_accept,
    input  logic [1:0]  i_req,
    input  logic [7:0]  i_address,
    input  logic [7:0]  i_command,
    output t_result     o_result
);

    localparam int DW = DURATION_BITS;

    t_phase           r_phase,   n_phase;
    logic [SEG_W-1:0] r_seg,     n_seg;
    logic [DW-1:0]    r_dur,     n_dur;
    logic [7:0]       r_addr,    n_addr;
    logic [7:0]       r_cmd,     n_cmd;
    logic [7:0]       r_repeats, n_repeats;
    logic [7:0]       r_gap,     n_gap;
    logic [15:0]      r_presc,   n_presc;

    logic [SEG_W:0]   seg_inc;
    logic [SEG_W-1:0] nxt_idx;
    logic [7:0]       data_byte;
    logic [DW-1:0]    nxt_bits_len;
    logic [DW-1:0]    dur_dec;
    logic [15:0]      presc_inc;
    logic [15:0]      tpm;
    logic [7:0]       gap_dec;
    logic             in_frame;
    logic             fend;
    logic             status;

    // Length register cut to the counter width; zero counts as one.
    function automatic logic [DW-1:0] fit_len(input logic [15:0] v);
        logic [DW-1:0] r;
        r = DW'(v);
        if (r == '0) begin
            r = DW'(1);
        end
        return r;
    endfunction

    assign seg_inc   = (SEG_W+1)'(r_seg) + (SEG_W+1)'(1);
    assign nxt_idx   = seg_inc[SEG_W-1:0];
    assign dur_dec   = (r_dur != '0) ? r_dur - DW'(1) : '0;
    assign presc_inc = r_presc + 16'd1;
    assign tpm       = (i_cfg.ticks_per_ms == 16'd0) ? 16'd1 : i_cfg.ticks_per_ms;
    assign gap_dec   = (r_gap != 8'd0) ? r_gap - 8'd1 : 8'd0;
    assign in_frame  = (r_phase == PH_START_MARK) || (r_phase == PH_START_SPACE) ||
                       (r_phase == PH_BITS);

    // Length of the bit segment that follows the current one.
    always_comb begin
        if (nxt_idx < ADDR_END_IDX) begin
            data_byte = r_addr;
        end else if (nxt_idx < CMD_END_IDX) begin
            data_byte = r_cmd;
        end else begin
            data_byte = ~r_cmd;
        end
        if (!nxt_idx[0]) begin
            nxt_bits_len = fit_len(i_cfg.bit_mark_ticks);
        end else if (data_byte[nxt_idx[3:1]]) begin
            nxt_bits_len = fit_len(i_cfg.one_space_ticks);
        end else begin
            nxt_bits_len = fit_len(i_cfg.zero_space_ticks);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_seg     = r_seg;
        n_dur     = r_dur;
        n_addr    = r_addr;
        n_cmd     = r_cmd;
        n_repeats = r_repeats;
        n_gap     = r_gap;
        n_presc   = r_presc;
        fend      = 1'b0;
        status    = 1'b0;
        case (t_req'(i_req))
            REQ_START: begin
                n_addr    = i_address;
                n_cmd     = i_command;
                n_repeats = i_cfg.repeat_count;
                n_phase   = PH_START_MARK;
                n_seg     = '0;
                n_dur     = fit_len(i_cfg.start_mark_ticks);
            end
            REQ_STOP: begin
                if ((r_repeats != 8'd0) || in_frame) begin
                    status = 1'b1;
                end else begin
                    n_phase = PH_IDLE;
                    n_seg   = '0;
                    n_dur   = '0;
                    n_gap   = 8'd0;
                    n_presc = 16'd0;
                end
            end
            REQ_TICK: begin
                if (in_frame) begin
                    n_dur = dur_dec;
                    if (dur_dec == '0) begin
                        if (r_phase == PH_START_MARK) begin
                            n_phase = PH_START_SPACE;
                            n_dur   = fit_len(i_cfg.start_space_ticks);
                        end else if (r_phase == PH_START_SPACE) begin
                            n_phase = PH_BITS;
                            n_seg   = '0;
                            n_dur   = fit_len(i_cfg.bit_mark_ticks);
                        end else if (seg_inc < (SEG_W+1)'(FRAME_SEGMENTS)) begin
                            n_seg = nxt_idx;
                            n_dur = nxt_bits_len;
                        end else begin
                            n_phase = PH_GAP;
                            n_seg   = '0;
                            n_dur   = '0;
                            n_gap   = (i_cfg.repeat_gap_ms == 8'd0) ? 8'd1
                                                                    : i_cfg.repeat_gap_ms;
                            n_presc = 16'd0;
                            fend    = 1'b1;
                        end
                    end
                end else if (r_phase == PH_GAP) begin
                    n_presc = presc_inc;
                    if (presc_inc >= tpm) begin
                        n_presc = 16'd0;
                        n_gap   = gap_dec;
                        if (gap_dec == 8'd0) begin
                            if (r_repeats != 8'd0) begin
                                n_repeats = r_repeats - 8'd1;
                            end
                            n_phase = PH_START_MARK;
                            n_seg   = '0;
                            n_dur   = fit_len(i_cfg.start_mark_ticks);
                        end
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_seg     <= '0;
            r_dur     <= '0;
            r_addr    <= 8'd0;
            r_cmd     <= 8'd0;
            r_repeats <= 8'd0;
            r_gap     <= 8'd0;
            r_presc   <= 16'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_seg     <= n_seg;
            r_dur     <= n_dur;
            r_addr    <= n_addr;
            r_cmd     <= n_cmd;
            r_repeats <= n_repeats;
            r_gap     <= n_gap;
            r_presc   <= n_presc;
        end
    end

    assign o_result.ir_on     = (n_phase == PH_START_MARK) ||
                                ((n_phase == PH_BITS) && !n_seg[0]);
    assign o_result.active    = (n_phase != PH_IDLE);
    assign o_result.frame_end = fend;
    assign o_result.status    = status;

endmodule

// ----- rtl/core/ipdfs_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdfs_out: result register
// One output register that takes a new result whenever it is empty or its
// beat is taken in the same cycle.
// ----------------------------------------------------------------------------
module ipdfs_out
    import ipdfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    input  logic       i_ready,
    output logic       o_can_load,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_last,
    output logic       o_user
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {6'd0, r_result.active, r_result.ir_on};
    assign o_last  = r_result.frame_end;
    assign o_user  = r_result.status;

endmodule

// ----- rtl/core/ir_pulse_distance_frame_sender.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_sender: pulse-distance IR frame envelope generator
// Builds the mark/space envelope of a 32-bit address/command IR frame with
// repeats, driven by tick, start and stop request beats.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata                            tuser          tlast
//  s_axis    in   [7:0] address, [15:8] command    [1:0] req_type -
//  m_axis    out  [0] ir_on, [1] active, [7:2] 0   [0] status     frame_end
//  cfg       in   i_cfg_wdata to register i_cfg_addr on i_cfg_we (no read-back)
//
// Every request beat gives exactly one result beat. The sequencer updates its
// state in the cycle a beat is accepted and the result appears on m_axis in
// the next cycle, from a single output register. Sustained rate is one beat
// per clock while m_axis_tready is high; the output register is the only stage.
// s_axis_tready is high whenever the output register is empty or its beat is
// taken in the same cycle, so s_axis stalls only for the cycles in which a
// waiting result is held back by m_axis_tready.
// Reset (synchronous, active low) returns the sequencer to idle, empties the
// output register and loads the register defaults.
//
// A frame is a start mark, a start space and FRAME_SEGMENTS alternating bit
// marks and spaces; each space carries one bit of address, address, command,
// inverted command, LSB first. A segment of length d is shown by the beat that
// loads it and the next d-1 ticks. After the frame the block counts the repeat
// gap in milliseconds of ticks and sends the frame again. A stop is refused
// with status set while a frame runs or repeats remain.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_sender
    import ipdfs_pkg::*;
#(
    parameter int FRAME_SEGMENTS = 65,
    parameter int DURATION_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request beats.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [7:0] address, [15:8] command
    input  logic [1:0]            s_axis_tuser,   // [1:0] req_type
    // Result beats.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [0] ir_on, [1] active, [7:2] zero
    output logic                  m_axis_tlast,   // frame_end
    output logic                  m_axis_tuser,   // [0] status
    // Configuration writes.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result seq_result;
    logic    can_load;
    logic    accept;

    // A request beat is taken whenever the output register can take its result.
    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    ipdfs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ipdfs_seq #(
        .FRAME_SEGMENTS (FRAME_SEGMENTS),
        .DURATION_BITS  (DURATION_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_req     (s_axis_tuser),
        .i_address (s_axis_tdata[7:0]),
        .i_command (s_axis_tdata[15:8]),
        .o_result  (seq_result)
    );

    ipdfs_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (seq_result),
        .i_ready    (m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_user     (m_axis_tuser)
    );

endmodule

// ----- rtl/core/ipdfs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdfs_checker: port-level checks of the frame sender
// Watches the stream ports for flow control and result consistency.
// ----------------------------------------------------------------------------
module ipdfs_checker
    import ipdfs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [15:0]           s_axis_tdata,
    input logic [1:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [7:0]            m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tuser,
    input logic                  i_cfg_we,
    input logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Every accepted request shows a result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted request gave no result");

    // Requests are taken whenever the result side can move.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("request held off with a free output register");

    // A frame ends into the gap: no carrier, still active.
    a_frame_end_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1] && !m_axis_tdata[0]))
        else $error("frame end outside the gap");

    // A refused stop is only reported while busy and never ends a frame.
    a_refused_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[1] && !m_axis_tlast))
        else $error("refused stop while idle");

endmodule

bind ir_pulse_distance_frame_sender ipdfs_checker u_ipdfs_checker (.*);

// ----- dv/ir_pulse_distance_frame_sender_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_sender_tb: self-checking bench for the IR frame sender
// Request beats are fed from a queue in bursts while the result side stalls
// on its own pattern. An envelope predictor in the bench tracks the sequencer
// and every result beat is compared field by field against it, across the
// reset settings, all-maximum settings, all-zero settings and random short
// timings that let whole frames, gaps, resends and stops play out.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_sender_tb;
    import ipdfs_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int FRAME_SEGS = 65;
    localparam int RAND_PHASES = 5;
    localparam int RAND_BEATS  = 110;
    localparam int MAX_REPORTS = 10;

    // Request code 3 is not part of the request enum; the block must ignore it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] address;
        logic [7:0] command;
    } t_ir_request;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts at a known
    // value at time zero.
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // [7:0] address, [15:8] command
    logic [1:0]            s_axis_tuser = '0;   // [1:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [0] ir_on, [1] active, [7:2] zero
    logic                  m_axis_tlast;        // frame_end
    logic                  m_axis_tuser;        // [0] status
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    always #CLK_HALF i_clk = ~i_clk;

    ir_pulse_distance_frame_sender #(
        .FRAME_SEGMENTS(FRAME_SEGS),
        .DURATION_BITS (16)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Envelope predictor. It keeps its own copy of the registers and of the
    // sequencer state and is advanced once per accepted request beat.
    // ------------------------------------------------------------------------
    t_cfg        sender_cfg;
    t_phase      env_phase;
    logic [6:0]  seg_idx;
    logic [15:0] seg_ticks_left;
    logic [7:0]  held_addr;
    logic [7:0]  held_cmd;
    logic [7:0]  resends_left;
    logic [7:0]  gap_ms_left;
    logic [15:0] ms_ticks;

    // A programmed length of zero behaves as one tick.
    function automatic logic [15:0] clamp_len(input logic [15:0] len);
        return (len == 16'd0) ? 16'd1 : len;
    endfunction

    // Even segments are bit marks; odd ones are spaces whose length encodes
    // one bit of address, address, command or inverted command, LSB first.
    // Spaces from index 48 on all take the inverted command.
    function automatic logic [15:0] bit_segment_len(input logic [6:0] idx);
        logic [7:0] data_byte;
        if (!idx[0])
            return clamp_len(sender_cfg.bit_mark_ticks);
        if (idx < ADDR_END_IDX)
            data_byte = held_addr;
        else if (idx < CMD_END_IDX)
            data_byte = held_cmd;
        else
            data_byte = ~held_cmd;
        return data_byte[idx[3:1]] ? clamp_len(sender_cfg.one_space_ticks)
                                   : clamp_len(sender_cfg.zero_space_ticks);
    endfunction

    function automatic void start_frame();
        env_phase      = PH_START_MARK;
        seg_idx        = '0;
        seg_ticks_left = clamp_len(sender_cfg.start_mark_ticks);
    endfunction

    // Moves on from the segment that has just run out. Returns one when the
    // closing mark ended and the gap begins.
    function automatic logic close_segment();
        if (env_phase == PH_START_MARK) begin
            env_phase      = PH_START_SPACE;
            seg_ticks_left = clamp_len(sender_cfg.start_space_ticks);
            return 1'b0;
        end
        if (env_phase == PH_START_SPACE) begin
            env_phase      = PH_BITS;
            seg_idx        = '0;
            seg_ticks_left = bit_segment_len(7'd0);
            return 1'b0;
        end
        if (int'(seg_idx) + 1 < FRAME_SEGS) begin
            seg_idx        = seg_idx + 7'd1;
            seg_ticks_left = bit_segment_len(seg_idx);
            return 1'b0;
        end
        env_phase      = PH_GAP;
        seg_idx        = '0;
        seg_ticks_left = '0;
        gap_ms_left    = (sender_cfg.repeat_gap_ms == 8'd0) ? 8'd1 : sender_cfg.repeat_gap_ms;
        ms_ticks       = '0;
        return 1'b1;
    endfunction

    // Applies one request beat and returns the envelope shown after it.
    function automatic t_result next_envelope(input t_ir_request rq);
        t_result     env;
        logic        in_frame;
        logic [15:0] tick_limit;
        env      = '0;
        in_frame = (env_phase == PH_START_MARK) || (env_phase == PH_START_SPACE) ||
                   (env_phase == PH_BITS);
        case (rq.req)
            REQ_START: begin
                // A start always restarts at once, even in the middle of a frame.
                held_addr    = rq.address;
                held_cmd     = rq.command;
                resends_left = sender_cfg.repeat_count;
                start_frame();
            end
            REQ_STOP: begin
                // Refused while a frame runs or resends are still owed.
                if (resends_left != 8'd0 || in_frame) begin
                    env.status = 1'b1;
                end else begin
                    env_phase      = PH_IDLE;
                    seg_idx        = '0;
                    seg_ticks_left = '0;
                    gap_ms_left    = '0;
                    ms_ticks       = '0;
                end
            end
            REQ_TICK: begin
                if (in_frame) begin
                    if (seg_ticks_left != 16'd0)
                        seg_ticks_left = seg_ticks_left - 16'd1;
                    if (seg_ticks_left == 16'd0)
                        env.frame_end = close_segment();
                end else if (env_phase == PH_GAP) begin
                    tick_limit = clamp_len(sender_cfg.ticks_per_ms);
                    ms_ticks   = ms_ticks + 16'd1;
                    if (ms_ticks >= tick_limit) begin
                        ms_ticks = '0;
                        if (gap_ms_left != 8'd0)
                            gap_ms_left = gap_ms_left - 8'd1;
                        if (gap_ms_left == 8'd0) begin
                            if (resends_left != 8'd0)
                                resends_left = resends_left - 8'd1;
                            start_frame();
                        end
                    end
                end
            end
            default: ;  // the unused code changes nothing
        endcase
        env.ir_on  = (env_phase == PH_START_MARK) || (env_phase == PH_BITS && !seg_idx[0]);
        env.active = (env_phase != PH_IDLE);
        return env;
    endfunction

    // ------------------------------------------------------------------------
    // Bookkeeping shared by the driver, the monitor and the sequence.
    // ------------------------------------------------------------------------
    t_ir_request request_q[$];
    t_result     envelope_q[$];
    t_ir_request live_req;
    t_result     want_env;
    int          beats_planned = 0;
    int          beats_taken   = 0;
    int          results_seen  = 0;
    int          fault_count   = 0;
    int          burst_left    = 0;
    int          idle_left     = 0;
    int          ready_mode    = 0;
    int          mode_left     = 0;

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Driver. A beat stays on the bus until it is taken. Beats go out in
    // bursts of random length; between bursts tvalid drops for an idle gap,
    // and now and then a long burst runs with no gap at all. The predictor is
    // advanced at the edge where a beat is accepted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            idle_left  = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                envelope_q.push_back(next_envelope(live_req));
                beats_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    live_req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {live_req.command, live_req.address};
                    s_axis_tuser  <= live_req.req;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(40, 120);
                            idle_left  = 0;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            idle_left  = $urandom_range(1, 6);
                        end
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. tready follows a pattern that switches between always ready,
    // light stalls and heavy stalls. Every taken result beat is checked
    // against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            mode_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (envelope_q.size() == 0) begin
                    report_fault($sformatf(
                        "result beat %0d arrived with no prediction: %s%02h %s%0b %s%0b",
                        results_seen, "tdata=", m_axis_tdata, "tlast=", m_axis_tlast,
                        "tuser=", m_axis_tuser));
                end else begin
                    want_env = envelope_q.pop_front();
                    if (m_axis_tdata[0] !== want_env.ir_on ||
                        m_axis_tdata[1] !== want_env.active ||
                        m_axis_tdata[7:2] !== 6'd0 ||
                        m_axis_tlast !== want_env.frame_end ||
                        m_axis_tuser !== want_env.status) begin
                        report_fault({
                            $sformatf("result beat %0d mismatch: expected ir_on=%0b ",
                                      results_seen, want_env.ir_on),
                            $sformatf("active=%0b frame_end=%0b status=%0b pad=00, ",
                                      want_env.active, want_env.frame_end,
                                      want_env.status),
                            $sformatf("got ir_on=%0b active=%0b frame_end=%0b ",
                                      m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast),
                            $sformatf("status=%0b pad=%02h",
                                      m_axis_tuser, m_axis_tdata[7:2])});
                    end
                end
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(8, 60);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers.
    // ------------------------------------------------------------------------
    task automatic plan_request(input logic [1:0] req, input logic [7:0] address,
                                input logic [7:0] command);
        t_ir_request rq;
        rq.req     = req;
        rq.address = address;
        rq.command = command;
        request_q.push_back(rq);
        beats_planned++;
    endtask

    // A tick with random bytes alongside; the bytes only matter on a start.
    task automatic plan_tick();
        plan_request(REQ_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Waits until every planned beat is taken and its result checked, then
    // lets the single output stage settle before anything else is touched.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (beats_taken != beats_planned || envelope_q.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_START_MARK:  sender_cfg.start_mark_ticks  = value;
            CFG_START_SPACE: sender_cfg.start_space_ticks = value;
            CFG_BIT_MARK:    sender_cfg.bit_mark_ticks    = value;
            CFG_ONE_SPACE:   sender_cfg.one_space_ticks   = value;
            CFG_ZERO_SPACE:  sender_cfg.zero_space_ticks  = value;
            CFG_REPEAT_GAP:  sender_cfg.repeat_gap_ms     = value[7:0];
            CFG_REPEAT_CNT:  sender_cfg.repeat_count      = value[7:0];
            default:         sender_cfg.ticks_per_ms      = value;
        endcase
    endtask

    // Writes all eight registers back to back. The 8-bit registers get random
    // upper bits on the bus, which the block has to drop.
    task automatic load_settings(input logic [15:0] start_mark, input logic [15:0] start_space,
                                 input logic [15:0] bit_mark, input logic [15:0] one_space,
                                 input logic [15:0] zero_space, input logic [7:0] gap_ms,
                                 input logic [7:0] repeats, input logic [15:0] tick_div);
        write_reg(CFG_START_MARK, start_mark);
        write_reg(CFG_START_SPACE, start_space);
        write_reg(CFG_BIT_MARK, bit_mark);
        write_reg(CFG_ONE_SPACE, one_space);
        write_reg(CFG_ZERO_SPACE, zero_space);
        write_reg(CFG_REPEAT_GAP, {8'($urandom_range(0, 255)), gap_ms});
        write_reg(CFG_REPEAT_CNT, {8'($urandom_range(0, 255)), repeats});
        write_reg(CFG_TICKS_MS, tick_div);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        int pick;

        // Predictor starts from the reset defaults.
        sender_cfg.start_mark_ticks  = RST_START_MARK;
        sender_cfg.start_space_ticks = RST_START_SPACE;
        sender_cfg.bit_mark_ticks    = RST_BIT_MARK;
        sender_cfg.one_space_ticks   = RST_ONE_SPACE;
        sender_cfg.zero_space_ticks  = RST_ZERO_SPACE;
        sender_cfg.repeat_gap_ms     = RST_REPEAT_GAP;
        sender_cfg.repeat_count      = RST_REPEAT_CNT;
        sender_cfg.ticks_per_ms      = RST_TICKS_MS;
        env_phase      = PH_IDLE;
        seg_idx        = '0;
        seg_ticks_left = '0;
        held_addr      = '0;
        held_cmd       = '0;
        resends_left   = '0;
        gap_ms_left    = '0;
        ms_ticks       = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks at the reset settings: a tick and the unused code
        // while idle, a stop that idle accepts, a start with extreme bytes, a
        // stop refused mid-frame, and a start that restarts a busy frame.
        plan_tick();
        plan_request(REQ_UNUSED, 8'hFF, 8'hFF);
        plan_request(REQ_STOP, 8'h00, 8'h00);
        plan_request(REQ_START, 8'h00, 8'hFF);
        plan_request(REQ_STOP, 8'hFF, 8'h00);
        repeat (3) plan_tick();
        plan_request(REQ_UNUSED, 8'h00, 8'h00);
        plan_request(REQ_START, 8'hFF, 8'h00);
        plan_tick();
        plan_request(REQ_STOP, 8'h5A, 8'hA5);
        wait_drained();

        // Every register at its largest value. The frame cannot finish here,
        // but the start mark is loaded and counted with full-width lengths.
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      8'hFF, 8'hFF, 16'hFFFF);
        plan_request(REQ_START, 8'h5A, 8'hC3);
        repeat (3) plan_tick();
        plan_request(REQ_STOP, 8'h00, 8'h00);
        wait_drained();

        // Random phases. The first uses all-zero registers, which behave as
        // the shortest timing; the rest draw short random timings so that
        // frames complete, gaps run out and resends or stops follow. Each
        // phase opens with a start and is mostly ticks, with a few stops,
        // restarts and unused codes mixed in.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0)
                load_settings('0, '0, '0, '0, '0, '0, '0, '0);
            else
                load_settings(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                              16'($urandom_range(0, 1)), 16'($urandom_range(0, 2)),
                              16'($urandom_range(0, 1)), 8'($urandom_range(0, 6)),
                              8'($urandom_range(0, 2)), 16'($urandom_range(0, 5)));
            plan_request(REQ_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            for (int n = 1; n < RAND_BEATS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 1)
                    plan_request(REQ_UNUSED, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                else if (pick < 2)
                    plan_request(REQ_START, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                else if (pick < 6)
                    plan_request(REQ_STOP, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                else
                    plan_tick();
            end
            wait_drained();
        end

        // Let the output stage settle once more, then give the verdict.
        repeat (4) @(posedge i_clk);
        if (envelope_q.size() != 0)
            report_fault($sformatf("%0d predicted results never arrived", envelope_q.size()));
        if (fault_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- ir_pulse_distance_frame_sender.f -----
rtl/core/ipdfs_pkg.sv
rtl/core/ipdfs_cfg.sv
rtl/core/ipdfs_seq.sv
rtl/core/ipdfs_out.sv
rtl/core/ir_pulse_distance_frame_sender.sv
rtl/core/ipdfs_checker.sv
dv/ir_pulse_distance_frame_sender_tb.sv
